### rtl/wsp_pkg.sv
// Shared types and constants for the wheel speed estimator.
// Used by the front end, the command queue, the divider and the back end.
package wsp_pkg;

  localparam int NUM_WHEELS = 4;
  localparam int OUT_FIELDS = 4;
  localparam int WHEEL_W    = 2;
  localparam int TIME_W     = 32;
  localparam int SPEED_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [SPEED_W-1:0] SPEED_MAX = '1;
  localparam logic [TIME_W-1:0]  STALE_RESET = '1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_NUMERATOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERIOD      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STALE_PERIOD    = 2'd2;

  // input mode codes
  localparam logic MODE_EDGE    = 1'b0;
  localparam logic MODE_TIMEOUT = 1'b1;

  typedef enum logic [1:0] {
    OP_EDGE    = 2'd0,  // tooth edge on a known wheel
    OP_STALE   = 2'd1,  // edge on a wheel beyond the count: stale zeroing only
    OP_TIMEOUT = 2'd2   // zero all speeds and report
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [WHEEL_W-1:0] wheel;
    logic [TIME_W-1:0]  timestamp;
  } cmd_t;

  typedef struct packed {
    logic [TIME_W-1:0] speed_numerator;
    logic [TIME_W-1:0] min_period;
    logic [TIME_W-1:0] stale_period;
  } cfg_t;

endpackage

### rtl/wheel_speed_from_tooth_period_core.sv
// Wheel speed estimator from tooth-edge timestamps: top level.
// Holds the configuration registers; depends on wsp_pkg, wsp_front,
// wsp_queue and wsp_back.
//
// Usage:
//   The input stream carries one request per tooth edge or timeout. tuser
//   holds the mode and the wheel index, tdata the 32-bit timer count.
//   Every accepted timeout and every accepted edge whose period passes the
//   minimum check yields one result on the output stream: the four speeds
//   packed in tdata. Edges with a short period or an unknown wheel only
//   zero stale wheels and yield nothing.
//   Requests land in a two-entry queue, so the input keeps accepting while
//   the back end works. An edge passes through the back end in order: the
//   pop and check, the radix-2 divider (its steps and the done flag), and
//   the final step that updates the speeds and loads the result register.
//   Timeouts and zero periods skip the divider; dropped edges end at the check.
//   When the receiver stalls, the result holds in the output register and
//   the back end waits in its final step; the queue then fills and
//   in_tready falls.
//   Reset (rst_n low, synchronous) clears speeds, timestamps, the queue and
//   the output valid flag; speed_numerator and min_period reset to 0 and
//   stale_period to all ones. Write configuration only while idle.
module wheel_speed_from_tooth_period_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [31:0]                     in_tdata,   // [31:0] timestamp
  input  logic [2:0]                      in_tuser,   // [0] mode, [2:1] wheel
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [63:0]                     out_tdata,  // [15:0] speed_0, [31:16] speed_1,
                                                      // [47:32] speed_2, [63:48] speed_3
  input  logic                            cfg_we,
  input  logic [wsp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wsp_pkg::TIME_W-1:0]      cfg_wdata
);
  import wsp_pkg::*;

  cfg_t               cfg_r;
  cmd_t               front_cmd;
  cmd_t               queue_cmd;
  logic               queue_valid;
  logic               back_ready;
  logic [SPEED_W-1:0] speed [OUT_FIELDS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed_numerator <= '0;
      cfg_r.min_period      <= '0;
      cfg_r.stale_period    <= STALE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SPEED_NUMERATOR: cfg_r.speed_numerator <= cfg_wdata;
        CFG_MIN_PERIOD:      cfg_r.min_period      <= cfg_wdata;
        CFG_STALE_PERIOD:    cfg_r.stale_period    <= cfg_wdata;
        default: begin
          // ignore writes beyond the register list
        end
      endcase
    end
  end

  wsp_front u_front (
    .in_mode      (in_tuser[0]),
    .in_wheel     (in_tuser[2:1]),
    .in_timestamp (in_tdata),
    .cmd          (front_cmd)
  );

  wsp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_tvalid),
    .push_ready (in_tready),
    .push_cmd   (front_cmd),
    .pop_valid  (queue_valid),
    .pop_ready  (back_ready),
    .pop_cmd    (queue_cmd)
  );

  wsp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (queue_valid),
    .cmd_ready (back_ready),
    .cmd       (queue_cmd),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_speed (speed)
  );

  always_comb begin
    for (int j = 0; j < OUT_FIELDS; j++) begin
      out_tdata[j*SPEED_W +: SPEED_W] = speed[j];
    end
  end

endmodule

### rtl/wsp_front.sv
// Front end: takes input requests and classifies them into queue commands.
// Depends on wsp_pkg.
module wsp_front (
  input  logic                              in_mode,
  input  logic [wsp_pkg::WHEEL_W-1:0]       in_wheel,
  input  logic [wsp_pkg::TIME_W-1:0]        in_timestamp,
  output wsp_pkg::cmd_t                     cmd
);
  import wsp_pkg::*;

  localparam logic [WHEEL_W:0] WHEEL_LIMIT = (WHEEL_W+1)'(NUM_WHEELS);

  logic wheel_known;

  assign wheel_known = ({1'b0, in_wheel} < WHEEL_LIMIT);

  always_comb begin
    cmd.wheel     = in_wheel;
    cmd.timestamp = in_timestamp;
    if (in_mode == MODE_TIMEOUT) begin
      cmd.op = OP_TIMEOUT;
    end else if (wheel_known) begin
      cmd.op = OP_EDGE;
    end else begin
      cmd.op = OP_STALE;
    end
  end

endmodule

### rtl/wsp_queue.sv
// Short command queue between the front end and the back end.
// Depends on wsp_pkg for the command type and depth.
module wsp_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  wsp_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output wsp_pkg::cmd_t pop_cmd
);
  import wsp_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  cmd_t             entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != (PTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### rtl/wsp_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on wsp_pkg for the word width.
module wsp_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [wsp_pkg::TIME_W-1:0] numer,
  input  logic [wsp_pkg::TIME_W-1:0] denom,
  output logic                       done,
  output logic [wsp_pkg::TIME_W-1:0] quot
);
  import wsp_pkg::*;

  localparam int CNT_W = $clog2(TIME_W);

  logic [TIME_W-1:0] rem_r, rem_nxt;
  logic [TIME_W-1:0] quo_r, quo_nxt;
  logic [TIME_W-1:0] den_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [TIME_W:0]   trial;
  logic [TIME_W:0]   diff;

  assign trial = {rem_r, quo_r[TIME_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign done  = done_r;
  assign quot  = quo_r;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = numer;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[TIME_W]) begin
        rem_nxt = diff[TIME_W-1:0];
        quo_nxt = {quo_r[TIME_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[TIME_W-1:0];
        quo_nxt = {quo_r[TIME_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(TIME_W-1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      den_r <= denom;
    end
  end

endmodule

### rtl/wsp_back.sv
// Back end: stale zeroing, period check, speed update and result register.
// Depends on wsp_pkg and wsp_div.
module wsp_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  wsp_pkg::cfg_t               cfg,
  input  logic                        cmd_valid,
  output logic                        cmd_ready,
  input  wsp_pkg::cmd_t               cmd,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [wsp_pkg::SPEED_W-1:0] out_speed [wsp_pkg::OUT_FIELDS]
);
  import wsp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [TIME_W-1:0]  last_r  [NUM_WHEELS];
  logic [TIME_W-1:0]  last_nxt[NUM_WHEELS];
  logic [SPEED_W-1:0] speed_r  [NUM_WHEELS];
  logic [SPEED_W-1:0] speed_nxt[NUM_WHEELS];
  logic [SPEED_W-1:0] res_r  [OUT_FIELDS];
  logic [SPEED_W-1:0] res_nxt[OUT_FIELDS];
  logic               out_valid_r, out_valid_nxt;
  logic [WHEEL_W-1:0] pend_wheel_r, pend_wheel_nxt;
  logic [TIME_W-1:0]  pend_ts_r, pend_ts_nxt;
  logic [SPEED_W-1:0] pend_speed_r, pend_speed_nxt;
  logic               pend_timeout_r, pend_timeout_nxt;
  logic [TIME_W-1:0]  period;
  logic               div_start, div_done;
  logic [TIME_W-1:0]  div_quot;
  logic               out_free;

  assign cmd_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;
  assign period    = cmd.timestamp - last_r[cmd.wheel];

  always_comb begin
    for (int j = 0; j < OUT_FIELDS; j++) begin
      out_speed[j] = res_r[j];
    end
  end

  wsp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .numer (cfg.speed_numerator),
    .denom (period),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    state_nxt        = state_r;
    last_nxt         = last_r;
    speed_nxt        = speed_r;
    res_nxt          = res_r;
    out_valid_nxt    = out_valid_r;
    pend_wheel_nxt   = pend_wheel_r;
    pend_ts_nxt      = pend_ts_r;
    pend_speed_nxt   = pend_speed_r;
    pend_timeout_nxt = pend_timeout_r;
    div_start        = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          pend_wheel_nxt   = cmd.wheel;
          pend_ts_nxt      = cmd.timestamp;
          pend_timeout_nxt = (cmd.op == OP_TIMEOUT);
          if (cmd.op == OP_TIMEOUT) begin
            for (int i = 0; i < NUM_WHEELS; i++) begin
              speed_nxt[i] = '0;
            end
            state_nxt = S_FIN;
          end else begin
            for (int i = 0; i < NUM_WHEELS; i++) begin
              if ((cmd.timestamp - last_r[i]) > cfg.stale_period) begin
                speed_nxt[i] = '0;
              end
            end
            // drop edges on unknown wheels and implausibly short periods
            if (cmd.op == OP_EDGE && period >= cfg.min_period) begin
              if (period == '0) begin
                pend_speed_nxt = SPEED_MAX;
                state_nxt      = S_FIN;
              end else begin
                div_start = 1'b1;
                state_nxt = S_DIV;
              end
            end
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          pend_speed_nxt = (div_quot[TIME_W-1:SPEED_W] != '0) ? SPEED_MAX
                                                              : div_quot[SPEED_W-1:0];
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          if (!pend_timeout_r) begin
            speed_nxt[pend_wheel_r] = pend_speed_r;
            last_nxt[pend_wheel_r]  = pend_ts_r;
          end
          for (int j = 0; j < OUT_FIELDS; j++) begin
            if (j < NUM_WHEELS) begin
              res_nxt[j] = speed_nxt[j];
            end else begin
              res_nxt[j] = '0;
            end
          end
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_WHEELS; i++) begin
        last_r[i]  <= '0;
        speed_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      last_r      <= last_nxt;
      speed_r     <= speed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r          <= res_nxt;
    pend_wheel_r   <= pend_wheel_nxt;
    pend_ts_r      <= pend_ts_nxt;
    pend_speed_r   <= pend_speed_nxt;
    pend_timeout_r <= pend_timeout_nxt;
  end

endmodule

### test/wheel_speed_checker.sv
// Checker for the wheel speed estimator: follows the configuration writes,
// predicts the four speeds for every accepted request and compares results.
// Depends on wsp_pkg for widths, register indexes and mode codes.
module wheel_speed_checker (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_tvalid,
  input  logic                                        in_tready,
  input  logic [wsp_pkg::TIME_W-1:0]                  in_tdata,   // [31:0] timestamp
  input  logic [wsp_pkg::WHEEL_W:0]                   in_tuser,   // [0] mode, [2:1] wheel
  input  logic                                        out_tvalid,
  input  logic                                        out_tready,
  input  logic [wsp_pkg::OUT_FIELDS*wsp_pkg::SPEED_W-1:0] out_tdata, // speed_0 lowest
  input  logic                                        cfg_we,
  input  logic [wsp_pkg::CFG_IDX_W-1:0]               cfg_index,
  input  logic [wsp_pkg::TIME_W-1:0]                  cfg_wdata,
  output int unsigned                                 mismatch_count,
  output int unsigned                                 pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  import wsp_pkg::*;

  typedef logic [OUT_FIELDS*SPEED_W-1:0] speeds_t;

  cfg_t              settings;
  logic [TIME_W-1:0] edge_time [NUM_WHEELS];
  logic [SPEED_W-1:0] speed    [NUM_WHEELS];
  speeds_t           expected_speeds [$];
  int unsigned       errors;

  initial begin
    errors = 0;
  end

  // Update the wheel state for one request; return 1 when it yields a result.
  function automatic bit update_speeds(input logic mode, input logic [WHEEL_W-1:0] wheel,
                                       input logic [TIME_W-1:0] now, output speeds_t speeds);
    logic [TIME_W-1:0] lag;
    logic [TIME_W-1:0] quotient;
    bit                produced;
    produced = 1'b1;
    if (mode == MODE_TIMEOUT) begin
      for (int i = 0; i < NUM_WHEELS; i++) speed[i] = '0;
    end else begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
        lag = now - edge_time[i];
        if (lag > settings.stale_period) speed[i] = '0;
      end
      if (int'(wheel) >= NUM_WHEELS) begin
        produced = 1'b0;
      end else begin
        lag = now - edge_time[wheel];
        if (lag < settings.min_period) begin
          produced = 1'b0;
        end else begin
          if (lag == '0) begin
            speed[wheel] = SPEED_MAX;
          end else begin
            quotient = settings.speed_numerator / lag;
            speed[wheel] = (quotient > TIME_W'(SPEED_MAX)) ? SPEED_MAX : quotient[SPEED_W-1:0];
          end
          edge_time[wheel] = now;
        end
      end
    end
    for (int j = 0; j < OUT_FIELDS; j++)
      speeds[j*SPEED_W +: SPEED_W] = (j < NUM_WHEELS) ? speed[j] : '0;
    return produced;
  endfunction

  always @(posedge clk) begin
    speeds_t want;
    speeds_t speeds;
    if (!rst_n) begin
      settings.speed_numerator = '0;
      settings.min_period      = '0;
      settings.stale_period    = STALE_RESET;
      for (int i = 0; i < NUM_WHEELS; i++) begin
        edge_time[i] = '0;
        speed[i]     = '0;
      end
      expected_speeds.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SPEED_NUMERATOR: settings.speed_numerator = cfg_wdata;
          CFG_MIN_PERIOD:      settings.min_period      = cfg_wdata;
          CFG_STALE_PERIOD:    settings.stale_period    = cfg_wdata;
          default: ;
        endcase
      end
      // compare before queueing, so a stray result never meets a fresh request
      if (out_tvalid && out_tready) begin
        if (expected_speeds.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, out_tdata);
          errors++;
        end else begin
          want = expected_speeds.pop_front();
          for (int j = 0; j < OUT_FIELDS; j++) begin
            if (out_tdata[j*SPEED_W +: SPEED_W] !== want[j*SPEED_W +: SPEED_W]) begin
              $display("%0t: speed_%0d mismatch, expected %0d, got %0d", $time, j,
                       want[j*SPEED_W +: SPEED_W], out_tdata[j*SPEED_W +: SPEED_W]);
              errors++;
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (update_speeds(in_tuser[0], in_tuser[WHEEL_W:1], in_tdata, speeds))
          expected_speeds.push_back(speeds);
      end
    end
    mismatch_count  <= errors;
    pending_results <= expected_speeds.size();
  end

endmodule

### test/wheel_speed_from_tooth_period_core_test.sv
// Testbench top for the wheel speed estimator: clock, reset, configuration
// phases, directed and random edge/timeout requests, receiver stalls, verdict.
// Depends on wsp_pkg, the block and wheel_speed_checker.
module wheel_speed_from_tooth_period_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import wsp_pkg::*;

  localparam int unsigned HALF_PERIOD  = 10;
  localparam int unsigned RESET_CYCLES = 5;
  localparam int unsigned IDLE_PCT     = 29;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 150;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_tvalid;
  logic                          in_tready;
  logic [TIME_W-1:0]             in_tdata;   // [31:0] timestamp
  logic [WHEEL_W:0]              in_tuser;   // [0] mode, [2:1] wheel
  logic                          out_tvalid;
  logic                          out_tready;
  logic [OUT_FIELDS*SPEED_W-1:0] out_tdata;  // [15:0] speed_0 .. [63:48] speed_3
  logic                          cfg_we;
  logic [CFG_IDX_W-1:0]          cfg_index;
  logic [TIME_W-1:0]             cfg_wdata;
  logic                          steady;
  logic                          hold_start;
  int unsigned                   mismatch_count;
  int unsigned                   pending_results;

  longint unsigned next_edge    [NUM_WHEELS];
  int unsigned     wheel_period [NUM_WHEELS];

  always #(HALF_PERIOD) clk = ~clk;

  wheel_speed_from_tooth_period_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  wheel_speed_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  // Offer one request, idling first at random; leave tvalid high afterwards.
  task automatic send_request(input logic mode, input logic [WHEEL_W-1:0] wheel,
                              input logic [TIME_W-1:0] stamp);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {wheel, mode};
    in_tdata  <= stamp;
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop the request line, wait for every result, then let the back end drain.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all registers back to back, plus one write to the unused index.
  task automatic load_settings(input logic [TIME_W-1:0] numerator,
                               input logic [TIME_W-1:0] shortest,
                               input logic [TIME_W-1:0] stale);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SPEED_NUMERATOR;
    cfg_wdata <= numerator;
    @(posedge clk);
    cfg_index <= CFG_MIN_PERIOD;
    cfg_wdata <= shortest;
    @(posedge clk);
    cfg_index <= CFG_STALE_PERIOD;
    cfg_wdata <= stale;
    @(posedge clk);
    cfg_index <= CFG_UNUSED;
    cfg_wdata <= $urandom;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic start_wheels(input int unsigned typ, input longint unsigned base);
    for (int i = 0; i < NUM_WHEELS; i++) begin
      wheel_period[i] = typ / 2 + $urandom_range(typ);
      next_edge[i]    = base + $urandom_range(wheel_period[i]);
    end
  endtask

  // Mostly time-ordered edges of four turning wheels; some timeouts and noise.
  task automatic random_request();
    int unsigned     r;
    int unsigned     j;
    int unsigned     p;
    int              pick;
    longint unsigned step;
    r = $urandom_range(99);
    if (r < 8) begin
      send_request(MODE_TIMEOUT, WHEEL_W'($urandom_range(3)), $urandom);
    end else if (r < 86) begin
      pick = 0;
      for (int i = 1; i < NUM_WHEELS; i++)
        if (next_edge[i] < next_edge[pick]) pick = i;
      send_request(MODE_EDGE, WHEEL_W'(pick), next_edge[pick][TIME_W-1:0]);
      p = wheel_period[pick];
      j = $urandom_range(99);
      if (j < 4)
        step = 0;                          // repeat the edge: zero period
      else if (j < 10)
        step = longint'(p) * 40;           // wheel stops for a while
      else
        step = p - p / 8 + $urandom_range(p / 4);
      next_edge[pick] += step;
    end else begin
      send_request(MODE_EDGE, WHEEL_W'($urandom_range(3)), $urandom);
    end
  endtask

  task automatic run_phase(input logic [TIME_W-1:0] numerator,
                           input logic [TIME_W-1:0] shortest,
                           input logic [TIME_W-1:0] stale,
                           input int unsigned typ, input longint unsigned base,
                           input int unsigned count);
    settle();
    load_settings(numerator, shortest, stale);
    start_wheels(typ, base);
    repeat (count) random_request();
  endtask

  // Receiver: random stalls, one long hold-off on request, none while steady.
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_start && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (steady) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    int unsigned typ;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= '0;
    cfg_we     <= 1'b0;
    cfg_index  <= '0;
    cfg_wdata  <= '0;
    steady     <= 1'b0;
    hold_start <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed: zero period, saturation, wrap, full-range period, timeout
    load_settings(32'h0001_0000, 32'h0, 32'hFFFF_FFFF);
    send_request(MODE_EDGE, 2'd0, 32'h0000_0000);
    send_request(MODE_EDGE, 2'd1, 32'h0000_0010);
    send_request(MODE_EDGE, 2'd2, 32'h0000_0001);
    send_request(MODE_EDGE, 2'd3, 32'hFFFF_FFFF);
    send_request(MODE_EDGE, 2'd3, 32'h0000_0010);
    send_request(MODE_TIMEOUT, 2'd3, $urandom);
    send_request(MODE_EDGE, 2'd1, 32'h0000_0110);

    // directed: short periods dropped, stale wheels zeroed
    settle();
    load_settings(32'hFFFF_FFFF, 32'h0000_0100, 32'h0000_1000);
    send_request(MODE_EDGE, 2'd0, 32'h0000_0080);
    send_request(MODE_EDGE, 2'd0, 32'h0000_0100);
    send_request(MODE_EDGE, 2'd2, 32'h0000_5000);
    send_request(MODE_EDGE, 2'd2, 32'h0000_5000);
    send_request(MODE_TIMEOUT, 2'd0, 32'hFFFF_FFFF);

    // directed: extreme settings, almost everything dropped
    settle();
    load_settings(32'h0, 32'hFFFF_FFFF, 32'h0);
    send_request(MODE_EDGE, 2'd3, 32'h0000_000F);
    send_request(MODE_EDGE, 2'd0, 32'h1234_5678);
    send_request(MODE_TIMEOUT, 2'd1, 32'h0);

    settle();
    load_settings(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    send_request(MODE_EDGE, 2'd1, 32'hAAAA_AAAA);
    send_request(MODE_EDGE, 2'd2, 32'h5555_5555);
    send_request(MODE_EDGE, 2'd0, 32'h0000_FFFF);
    send_request(MODE_EDGE, 2'd3, 32'hFFFF_0000);

    // random phases; the first runs without idling and wraps the timer
    steady <= 1'b1;
    run_phase(32'h0200_0000, 32'h0, 32'hFFFF_FFFF, 3000, 64'hFFFF_F000, 120);
    settle();
    steady     <= 1'b0;
    hold_start <= 1'b1;
    run_phase(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 70000, $urandom, 120);
    typ = $urandom_range(500, 5000);
    run_phase($urandom, typ * 3 / 4, typ * 6, typ, $urandom, 150);
    run_phase(32'h0, 32'h0, 32'h0, 1000, $urandom, 80);
    run_phase($urandom, 32'hFFFF_FFFF, $urandom, 2000, $urandom, 40);
    run_phase($urandom, $urandom_range(2000), $urandom_range(100, 100000),
              $urandom_range(50, 3000), $urandom, 100);
    run_phase(32'h00FF_FFFF, 32'h1, 32'hFFFF_FFFF, 200, $urandom, 100);

    settle();
    if (mismatch_count == 0 && pending_results == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
